>>> rtl/core/epd_pkg.sv
// ----------------------------------------------------------------------------
// epd_pkg: shared definitions for the escaped packet deframer
// Result kind codes, field widths and configuration register defaults.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;
  localparam int unsigned CfgIdxW = 2;

  // result kinds
  localparam logic [KindW-1:0] KindData    = 3'd0;
  localparam logic [KindW-1:0] KindOk      = 3'd1;
  localparam logic [KindW-1:0] KindCsumErr = 3'd2;
  localparam logic [KindW-1:0] KindTimeout = 3'd3;
  localparam logic [KindW-1:0] KindBadLen  = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSync   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEscape = 2'd1;

  // configuration reset values
  localparam logic [ByteW-1:0] SyncReset   = 8'hE0;
  localparam logic [ByteW-1:0] EscapeReset = 8'hD0;

endpackage

>>> rtl/core/escaped_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// escaped_packet_deframer_core: escaped byte-stream frame decoder
// Unescapes received bytes, tracks destination, length and payload, and
// reports data bytes and frame end status with a running mod-256 checksum.
// ----------------------------------------------------------------------------
// Results are registered: each appears on the output in the cycle after its input transfer.
// Throughput: one byte per cycle; the frame state and result register update
// together at every input transfer, and input stalls only while a result
// waits on a stalled output.
// Reset: asynchronous, active low; clears frame state, result valid and
// loads the sync and escape markers with their defaults.
module escaped_packet_deframer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [epd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [epd_pkg::ByteW-1:0]     cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [epd_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                          timeout_event_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [epd_pkg::KindW-1:0]     result_kind_o,
  output logic [epd_pkg::ByteW-1:0]     frame_destination_o,
  output logic [epd_pkg::ByteW-1:0]     frame_length_o,
  output logic [epd_pkg::ByteW-1:0]     byte_position_o,
  output logic [epd_pkg::ByteW-1:0]     payload_byte_o,
  output logic                          frame_end_o
);

  localparam logic [1:0] PhAddr   = 2'd0;
  localparam logic [1:0] PhLength = 2'd1;
  localparam logic [1:0] PhData   = 2'd2;

  logic [epd_pkg::ByteW-1:0] sync_q, escape_q;

  logic                      esc_q, esc_d;
  logic [1:0]                phase_q, phase_d;
  logic [epd_pkg::ByteW-1:0] cnt_q, cnt_d;
  logic [epd_pkg::ByteW-1:0] sum_q, sum_d;
  logic [epd_pkg::ByteW-1:0] dest_q, dest_d;
  logic [epd_pkg::ByteW-1:0] len_q, len_d;

  logic                      res_valid;
  logic [epd_pkg::KindW-1:0] res_kind;
  logic [epd_pkg::ByteW-1:0] res_pos;
  logic [epd_pkg::ByteW-1:0] res_byte;
  logic                      res_end;

  logic                      out_valid_q;
  logic [epd_pkg::KindW-1:0] kind_q;
  logic [epd_pkg::ByteW-1:0] rdest_q, rlen_q, pos_q, byte_q;
  logic                      end_q;

  logic                      in_xfer;
  logic [epd_pkg::ByteW-1:0] b_eff;
  logic                      last_byte;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  assign b_eff     = esc_q ? rx_byte_i + 8'd1 : rx_byte_i;
  assign last_byte = ({1'b0, cnt_q} + 9'd1) == {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= epd_pkg::SyncReset;
      escape_q <= epd_pkg::EscapeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        epd_pkg::RegSync:   sync_q   <= cfg_data_i;
        epd_pkg::RegEscape: escape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    esc_d     = esc_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    dest_d    = dest_q;
    len_d     = len_q;
    res_valid = 1'b0;
    res_kind  = epd_pkg::KindData;
    res_pos   = cnt_q;
    res_byte  = '0;
    res_end   = 1'b1;

    if (timeout_event_i) begin
      esc_d     = 1'b0;
      phase_d   = PhAddr;
      cnt_d     = '0;
      res_valid = 1'b1;
      res_kind  = epd_pkg::KindTimeout;
    end else if (!esc_q && rx_byte_i == sync_q) begin
      // sync wins over escape when both markers match
      phase_d = PhAddr;
      cnt_d   = '0;
    end else if (!esc_q && rx_byte_i == escape_q) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      case (phase_q)
        PhLength: begin
          len_d = b_eff;
          sum_d = sum_q + b_eff;
          if (b_eff == '0) begin
            phase_d   = PhAddr;
            cnt_d     = '0;
            res_valid = 1'b1;
            res_kind  = epd_pkg::KindBadLen;
            res_pos   = '0;
          end else begin
            phase_d = PhData;
          end
        end
        PhData: begin
          res_valid = 1'b1;
          if (last_byte) begin
            // final byte carries the checksum
            res_kind = (sum_q == b_eff) ? epd_pkg::KindOk : epd_pkg::KindCsumErr;
            phase_d  = PhAddr;
            cnt_d    = '0;
          end else begin
            res_kind = epd_pkg::KindData;
            res_byte = b_eff;
            res_end  = 1'b0;
            cnt_d    = cnt_q + 8'd1;
            sum_d    = sum_q + b_eff;
          end
        end
        default: begin
          // address phase, unused code acts the same
          dest_d  = b_eff;
          sum_d   = b_eff;
          cnt_d   = '0;
          phase_d = PhLength;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      phase_q <= PhAddr;
      cnt_q   <= '0;
      sum_q   <= '0;
      dest_q  <= '0;
      len_q   <= '0;
    end else if (in_xfer) begin
      esc_q   <= esc_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      dest_q  <= dest_d;
      len_q   <= len_d;
    end
  end

  // result register: load on every input transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_valid) begin
      kind_q  <= res_kind;
      rdest_q <= dest_d;
      rlen_q  <= len_d;
      pos_q   <= res_pos;
      byte_q  <= res_byte;
      end_q   <= res_end;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign result_kind_o       = kind_q;
  assign frame_destination_o = rdest_q;
  assign frame_length_o      = rlen_q;
  assign byte_position_o     = pos_q;
  assign payload_byte_o      = byte_q;
  assign frame_end_o         = end_q;

endmodule

>>> rtl/core/epd_checker.sv
// ----------------------------------------------------------------------------
// epd_checker: port-level checks for the escaped packet deframer
// Watches the top level ports and flags result and handshake slips.
// ----------------------------------------------------------------------------
module epd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        timeout_event_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [epd_pkg::KindW-1:0]   result_kind_o,
  input logic [epd_pkg::ByteW-1:0]   payload_byte_o,
  input logic [epd_pkg::ByteW-1:0]   byte_position_o,
  input logic                        frame_end_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(payload_byte_o) && $stable(byte_position_o))
    else $error("stalled result changed");

  // input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // a timeout transfer always yields a timeout result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && timeout_event_i |=>
      out_valid_o && result_kind_o == epd_pkg::KindTimeout)
    else $error("timeout transfer gave no timeout result");

  // only data results leave the frame open, and only they carry a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_end_o == (result_kind_o != epd_pkg::KindData))
      && (frame_end_o ? payload_byte_o == '0 : 1'b1))
    else $error("frame end flag or payload inconsistent with result kind");

endmodule

bind escaped_packet_deframer_core epd_checker u_epd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .timeout_event_i (timeout_event_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_kind_o   (result_kind_o),
  .payload_byte_o  (payload_byte_o),
  .byte_position_o (byte_position_o),
  .frame_end_o     (frame_end_o)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for escaped_packet_deframer_core
// Feeds a short directed byte stream, then random escaped frames, broken
// frames and noise under several sync and escape marker settings. Both
// channels see random gaps and stalls. A behavioral deframer predicts every
// result, and each output transfer is compared with it field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ClkHalf     = 2;
  localparam int CycleLimit  = 500000;
  localparam int RandomItems = 950;
  localparam int NumSettings = 5;
  localparam int LongHold    = 160;
  localparam int HoldAfter   = 300;

  typedef enum logic [1:0] {PhAddr, PhLength, PhData} frame_phase_e;

  typedef struct packed {
    logic [epd_pkg::KindW-1:0] kind;
    logic [epd_pkg::ByteW-1:0] dest;
    logic [epd_pkg::ByteW-1:0] length;
    logic [epd_pkg::ByteW-1:0] pos;
    logic [epd_pkg::ByteW-1:0] data;
    logic                      closes;
  } frame_result_t;

  typedef struct {
    logic [epd_pkg::ByteW-1:0] rx;
    logic                      tmo;
    bit                        typed;
    frame_result_t             res;
  } stim_row_t;

  localparam frame_result_t NoRes = '0;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [epd_pkg::CfgIdxW-1:0]  cfg_index_i     = epd_pkg::RegSync;
  logic [epd_pkg::ByteW-1:0]    cfg_data_i      = '0;
  logic                         in_valid_i      = 1'b0;
  logic                         in_stall_o;
  logic [epd_pkg::ByteW-1:0]    rx_byte_i       = '0;
  logic                         timeout_event_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i     = 1'b0;
  logic [epd_pkg::KindW-1:0]    result_kind_o;
  logic [epd_pkg::ByteW-1:0]    frame_destination_o;
  logic [epd_pkg::ByteW-1:0]    frame_length_o;
  logic [epd_pkg::ByteW-1:0]    byte_position_o;
  logic [epd_pkg::ByteW-1:0]    payload_byte_o;
  logic                         frame_end_o;

  escaped_packet_deframer_core DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .timeout_event_i    (timeout_event_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .frame_destination_o(frame_destination_o),
    .frame_length_o     (frame_length_o),
    .byte_position_o    (byte_position_o),
    .payload_byte_o     (payload_byte_o),
    .frame_end_o        (frame_end_o)
  );

  // deframer state as seen by the checker
  logic [epd_pkg::ByteW-1:0] sync_mark = epd_pkg::SyncReset;
  logic [epd_pkg::ByteW-1:0] esc_mark  = epd_pkg::EscapeReset;
  bit                        esc_pend  = 1'b0;
  frame_phase_e              phase     = PhAddr;
  logic [epd_pkg::ByteW-1:0] count     = '0;
  logic [epd_pkg::ByteW-1:0] csum      = '0;
  logic [epd_pkg::ByteW-1:0] held_dest = '0;
  logic [epd_pkg::ByteW-1:0] held_len  = '0;

  frame_result_t expected_results[$];
  stim_row_t     directed_rows[$];
  int            errors      = 0;
  int            items_taken = 0;
  int            cycles      = 0;
  bit            no_gaps     = 1'b0;
  bit            hold_done   = 1'b0;

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t: no progress, run stopped after %0d cycles", $time, cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Advance the frame state by one received byte; return 1 when it yields a result.
  function automatic bit deframe_byte(input logic [epd_pkg::ByteW-1:0] raw,
                                      input logic tmo,
                                      output frame_result_t res);
    logic [epd_pkg::ByteW-1:0] b;
    b   = raw;
    res = NoRes;
    if (tmo) begin
      res      = '{epd_pkg::KindTimeout, held_dest, held_len, count, 8'h00, 1'b1};
      esc_pend = 1'b0;
      phase    = PhAddr;
      count    = '0;
      return 1'b1;
    end
    if (!esc_pend && b == sync_mark) begin
      phase = PhAddr;
      count = '0;
      return 1'b0;
    end
    if (!esc_pend && b == esc_mark) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (esc_pend) begin
      b        = b + 8'd1;
      esc_pend = 1'b0;
    end
    case (phase)
      PhLength: begin
        held_len = b;
        csum     = csum + b;
        if (b == '0) begin
          res   = '{epd_pkg::KindBadLen, held_dest, held_len, 8'h00, 8'h00, 1'b1};
          phase = PhAddr;
          count = '0;
          return 1'b1;
        end
        phase = PhData;
        return 1'b0;
      end
      PhData: begin
        if (9'(count) + 9'd1 == 9'(held_len)) begin
          res   = '{(csum == b) ? epd_pkg::KindOk : epd_pkg::KindCsumErr,
                    held_dest, held_len, count, 8'h00, 1'b1};
          phase = PhAddr;
          count = '0;
          return 1'b1;
        end
        res   = '{epd_pkg::KindData, held_dest, held_len, count, b, 1'b0};
        count = count + 8'd1;
        csum  = csum + b;
        return 1'b1;
      end
      default: begin
        held_dest = b;
        csum      = b;
        count     = '0;
        phase     = PhLength;
        return 1'b0;
      end
    endcase
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [epd_pkg::ByteW-1:0] pick_byte();
    logic [epd_pkg::ByteW-1:0] v;
    do begin
      case ($urandom_range(0, 9))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = sync_mark;
        3:       v = esc_mark;
        default: v = 8'($urandom);
      endcase
      // with equal markers the marker value has no encoding
    end while (sync_mark == esc_mark && v == sync_mark);
    return v;
  endfunction

  function automatic void add_row(input logic [epd_pkg::ByteW-1:0] rx, input logic tmo,
                                  input bit typed, input frame_result_t res);
    stim_row_t row;
    row.rx    = rx;
    row.tmo   = tmo;
    row.typed = typed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(input string name,
                                      input logic [epd_pkg::ByteW-1:0] exp_v,
                                      input logic [epd_pkg::ByteW-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [epd_pkg::ByteW-1:0] rx, input logic tmo,
                           input bit typed, input frame_result_t typed_res);
    int            gap;
    bit            has_res;
    frame_result_t res;
    gap = no_gaps ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    rx_byte_i       <= rx;
    timeout_event_i <= tmo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_res = deframe_byte(rx, tmo, res);
    if (typed) expected_results.push_back(typed_res);
    else if (has_res) expected_results.push_back(res);
    items_taken++;
    @(negedge clk_i);
  endtask

  task automatic send_coded(input logic [epd_pkg::ByteW-1:0] v);
    if (sync_mark != esc_mark &&
        (v == sync_mark || v == esc_mark || $urandom_range(0, 9) == 0)) begin
      send_byte(esc_mark, 1'b0, 1'b0, NoRes);
      send_byte(v - 8'd1, 1'b0, 1'b0, NoRes);
    end else begin
      send_byte(v, 1'b0, 1'b0, NoRes);
    end
  endtask

  // Send one frame: mostly well formed, sometimes zero length, truncated or with a bad checksum.
  task automatic send_frame();
    logic [epd_pkg::ByteW-1:0] body[$];
    logic [epd_pkg::ByteW-1:0] len;
    logic [epd_pkg::ByteW-1:0] sum;
    logic [epd_pkg::ByteW-1:0] d;
    int                        r;
    int                        cut;
    r = $urandom_range(0, 99);
    if (r < 4) len = 8'h00;
    else if (r < 5) len = 8'($urandom_range(64, 255));
    else len = 8'($urandom_range(1, 10));
    body.push_back(pick_byte());
    body.push_back(len);
    sum = body[0] + len;
    for (int i = 1; i < int'(len); i++) begin
      d = pick_byte();
      body.push_back(d);
      sum = sum + d;
    end
    if (len != '0) body.push_back(($urandom_range(0, 9) == 0) ? pick_byte() : sum);
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, body.size() - 1) : body.size();
    if ($urandom_range(0, 4) != 0) send_byte(sync_mark, 1'b0, 1'b0, NoRes);
    for (int i = 0; i < cut; i++) send_coded(body[i]);
    if (cut < body.size() && $urandom_range(0, 1) == 0)
      send_byte(8'($urandom), 1'b1, 1'b0, NoRes);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       send_byte(8'($urandom), 1'b1, 1'b0, NoRes);
        1:       send_byte(esc_mark, 1'b0, 1'b0, NoRes);
        2:       send_byte(sync_mark, 1'b0, 1'b0, NoRes);
        default: send_byte(8'($urandom), 1'b0, 1'b0, NoRes);
      endcase
    end
  endtask

  // Drain the block, then write both markers back to back.
  task automatic reconfigure(input logic [epd_pkg::ByteW-1:0] s,
                             input logic [epd_pkg::ByteW-1:0] e);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= epd_pkg::RegSync;
    cfg_data_i  <= s;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sync_mark = s;
    @(negedge clk_i);
    cfg_index_i <= epd_pkg::RegEscape;
    cfg_data_i  <= e;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    esc_mark = e;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int busy;
    int free;
    @(posedge rst_ni);
    forever begin
      busy = gap_len();
      if (!hold_done && items_taken >= HoldAfter) begin
        busy      = LongHold;
        hold_done = 1'b1;
      end
      if (busy > 0) begin
        out_stall_i <= 1'b1;
        repeat (busy) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      free = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
      repeat (free + 1) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    frame_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result of kind %0d with none expected", $time, result_kind_o);
      end else begin
        exp_res = expected_results.pop_front();
        check_field("result_kind", 8'(exp_res.kind), 8'(result_kind_o));
        check_field("frame_destination", exp_res.dest, frame_destination_o);
        check_field("frame_length", exp_res.length, frame_length_o);
        check_field("byte_position", exp_res.pos, byte_position_o);
        check_field("payload_byte", exp_res.data, payload_byte_o);
        check_field("frame_end", 8'(exp_res.closes), 8'(frame_end_o));
      end
    end
  end

  initial begin
    logic [epd_pkg::ByteW-1:0] set_sync[NumSettings];
    logic [epd_pkg::ByteW-1:0] set_esc[NumSettings];
    int                        mark;

    set_sync = '{epd_pkg::SyncReset, 8'h00, 8'hFF, 8'h7E, 8'h00};
    set_esc  = '{epd_pkg::EscapeReset, 8'hFF, 8'h00, 8'h7E, 8'h00};

    // timeout while idle right after reset; the byte is ignored
    add_row(8'hE0, 1'b1, 1'b1, '{epd_pkg::KindTimeout, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
    // good frame with an escaped data byte
    add_row(8'h01, 1'b0, 1'b0, NoRes);
    add_row(8'h03, 1'b0, 1'b0, NoRes);
    add_row(8'h10, 1'b0, 1'b1, '{epd_pkg::KindData, 8'h01, 8'h03, 8'h00, 8'h10, 1'b0});
    add_row(8'hD0, 1'b0, 1'b0, NoRes);
    add_row(8'h0F, 1'b0, 1'b1, '{epd_pkg::KindData, 8'h01, 8'h03, 8'h01, 8'h10, 1'b0});
    add_row(8'h24, 1'b0, 1'b1, '{epd_pkg::KindOk, 8'h01, 8'h03, 8'h02, 8'h00, 1'b1});
    // top destination, length one, bad checksum
    add_row(8'hFF, 1'b0, 1'b0, NoRes);
    add_row(8'h01, 1'b0, 1'b0, NoRes);
    add_row(8'h55, 1'b0, 1'b1, '{epd_pkg::KindCsumErr, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b1});
    // zero length
    add_row(8'h00, 1'b0, 1'b0, NoRes);
    add_row(8'h00, 1'b0, 1'b1, '{epd_pkg::KindBadLen, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1});
    // checksum only
    add_row(8'h20, 1'b0, 1'b0, NoRes);
    add_row(8'h01, 1'b0, 1'b0, NoRes);
    add_row(8'h21, 1'b0, 1'b1, '{epd_pkg::KindOk, 8'h20, 8'h01, 8'h00, 8'h00, 1'b1});
    // both markers carried as escaped data
    add_row(8'h07, 1'b0, 1'b0, NoRes);
    add_row(8'h03, 1'b0, 1'b0, NoRes);
    add_row(8'hD0, 1'b0, 1'b0, NoRes);
    add_row(8'hDF, 1'b0, 1'b0, NoRes);
    add_row(8'hD0, 1'b0, 1'b0, NoRes);
    add_row(8'hCF, 1'b0, 1'b0, NoRes);
    add_row(8'hBA, 1'b0, 1'b0, NoRes);
    // sync mid-frame, then a timeout with an escape pending, then a sync
    add_row(8'h09, 1'b0, 1'b0, NoRes);
    add_row(8'hE0, 1'b0, 1'b0, NoRes);
    add_row(8'h0A, 1'b0, 1'b0, NoRes);
    add_row(8'h04, 1'b0, 1'b0, NoRes);
    add_row(8'h11, 1'b0, 1'b0, NoRes);
    add_row(8'hD0, 1'b0, 1'b0, NoRes);
    add_row(8'h5A, 1'b1, 1'b0, NoRes);
    add_row(8'hE0, 1'b0, 1'b0, NoRes);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].tmo, directed_rows[i].typed,
                directed_rows[i].res);

    for (int p = 0; p < NumSettings; p++) begin
      if (p == NumSettings - 1) begin
        set_sync[p] = 8'($urandom);
        set_esc[p]  = 8'($urandom);
      end
      reconfigure(set_sync[p], set_esc[p]);
      mark = items_taken;
      while (items_taken - mark < RandomItems / NumSettings) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 8) send_frame();
        else send_noise();
      end
      no_gaps = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
